[rtl/image_bin2x2_saturate_core_defines.svh]
// ----------------------------------------------------------------------------
// image_bin2x2_saturate_core_defines
// Assertion macros shared by the binning core and its result queue.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BIN2X2_SATURATE_CORE_DEFINES_SVH
`define IMAGE_BIN2X2_SATURATE_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define IB2S_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while reset is high
`define IB2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/ib2s_pkg.sv]
// ----------------------------------------------------------------------------
// ib2s_pkg
// Types and fixed constants of the 2x2 binning core.
// ----------------------------------------------------------------------------
package ib2s_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE_GAIN   = 2'd2;

  localparam int CFG_DATA_BITS = 16;

  // register reset values
  localparam logic [12:0] LINE_WIDTH_RESET   = 13'd4096;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd4096;
  localparam logic [15:0] SCALE_GAIN_RESET   = 16'd256;

  // gain is Q8.8 and the 2x2 sum is divided by four: shift by 8 + 2
  localparam int GAIN_SHIFT = 10;

  localparam int RESULT_MAX = 32767;
  localparam int RESULT_MIN = -32768;

  // result queue sizing
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_BITS = 3;
  localparam int OUT_CNT_BITS = 4;

  typedef struct packed {
    logic signed [15:0] binned_value;
    logic               frame_end;
  } result_t;

endpackage

[rtl/image_bin2x2_saturate_core.sv]
// ----------------------------------------------------------------------------
// image_bin2x2_saturate_core
// 2x2 pixel binning with Q8.8 gain and signed 16-bit saturation. Pixels come
// in raster order, one per clock at full rate. Each horizontal pair is summed;
// even rows park their pair sums in a line store RAM (MAX_WIDTH/2 entries,
// one read or one write per cycle), odd rows read the sum of the row above
// back and form trunc(sum4 * gain / 1024), clipped to [-32768, 32767]. A
// result goes from the pixel at odd row and odd column that causes it
// through line store read, 2x2 add, gain multiply, then rounding and
// clipping into an 8-entry result queue. in_ready stays high while fewer
// than 8 results are in flight or queued, so with out_ready held high one
// pixel is taken every clock. frame_end marks the last result of a frame; an
// odd last column or row is dropped. Writing line_width or frame_height
// restarts the frame; the line store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "image_bin2x2_saturate_core_defines.svh"

module image_bin2x2_saturate_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [ib2s_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // pixel input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [PIXEL_BITS-1:0]         pixel,
  // result output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   binned_value,
  output logic                                 frame_end
);

  import ib2s_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_BITS   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int PAIR_BITS  = PIXEL_BITS + 1;
  localparam int SUM4_BITS  = PIXEL_BITS + 2;
  localparam int PROD_BITS  = SUM4_BITS + 17;

  localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'((1 << GAIN_SHIFT) - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_HI     = PROD_BITS'(RESULT_MAX);
  localparam logic signed [PROD_BITS-1:0] SAT_LO     = PROD_BITS'(RESULT_MIN);

  // last column index of a row, from the raw register value
  function automatic logic [COL_BITS-1:0] width_last_of(input logic [12:0] v);
    int w;
    w = int'(v);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return COL_BITS'(w - 1);
  endfunction

  // last odd column, where the final pair of a row closes
  function automatic logic [COL_BITS-1:0] pair_col_last_of(input logic [12:0] v);
    int w;
    w = int'(v);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return COL_BITS'((w & ~1) - 1);
  endfunction

  function automatic logic [15:0] height_last_of(input logic [15:0] v);
    return (v < 16'd2) ? 16'd1 : v - 16'd1;
  endfunction

  function automatic logic [15:0] pair_row_last_of(input logic [15:0] v);
    return (v < 16'd2) ? 16'd1 : (v & 16'hFFFE) - 16'd1;
  endfunction

  // geometry, kept in the form the counters compare against
  logic [COL_BITS-1:0] width_last;
  logic [COL_BITS-1:0] pair_col_last;
  logic [15:0]         height_last;
  logic [15:0]         pair_row_last;
  logic [15:0]         scale_gain;

  // raster position and the pending even-column pixel
  logic [COL_BITS-1:0]         col;
  logic [15:0]                 row;
  logic signed [PIXEL_BITS-1:0] pair_sum;

  // pipeline
  logic                         s1_valid;
  logic                         s1_last;
  logic signed [PAIR_BITS-1:0]  s1_pair;
  logic                         s2_valid;
  logic                         s2_last;
  logic signed [SUM4_BITS-1:0]  s2_sum;
  logic                         s3_valid;
  logic                         s3_last;
  logic signed [PROD_BITS-1:0]  s3_prod;

  // result credits: items in the pipeline plus items in the queue
  logic [OUT_CNT_BITS-1:0] credit_used;

  logic                         cfg_fire;
  logic                         in_fire;
  logic                         out_fire;
  logic                         produce;
  logic                         line_we;
  logic                         line_re;
  logic [ADDR_BITS-1:0]         line_addr;
  logic signed [PAIR_BITS-1:0]  pair_now;
  logic [PAIR_BITS-1:0]         line_q;
  logic                         at_row_end;
  logic                         is_last;
  logic signed [PROD_BITS-1:0]  quot;
  result_t                      result;
  result_t                      q_head;
  logic [OUT_CNT_BITS-1:0]      q_count;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (credit_used < OUT_CNT_BITS'(OUT_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // pair close and line store access for the current pixel
  assign pair_now   = PAIR_BITS'(pair_sum) + PAIR_BITS'(pixel);
  assign line_addr  = ADDR_BITS'(col >> 1);
  assign line_we    = in_fire && col[0] && !row[0];
  assign line_re    = in_fire && col[0] && row[0];
  assign produce    = col[0] && row[0];
  assign at_row_end = (col == width_last);
  assign is_last    = (col == pair_col_last) && (row == pair_row_last);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last    <= width_last_of(LINE_WIDTH_RESET);
      pair_col_last <= pair_col_last_of(LINE_WIDTH_RESET);
      height_last   <= height_last_of(FRAME_HEIGHT_RESET);
      pair_row_last <= pair_row_last_of(FRAME_HEIGHT_RESET);
      scale_gain    <= SCALE_GAIN_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_LINE_WIDTH: begin
          width_last    <= width_last_of(cfg_data[12:0]);
          pair_col_last <= pair_col_last_of(cfg_data[12:0]);
        end
        CFG_FRAME_HEIGHT: begin
          height_last   <= height_last_of(cfg_data);
          pair_row_last <= pair_row_last_of(cfg_data);
        end
        CFG_SCALE_GAIN: begin
          scale_gain <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // raster counters, restarted by a geometry write
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pair_sum <= '0;
    end else if (cfg_fire && (cfg_index == CFG_LINE_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
      col      <= '0;
      row      <= '0;
      pair_sum <= '0;
    end else if (in_fire) begin
      if (!col[0]) begin
        pair_sum <= pixel;
      end
      if (at_row_end) begin
        col <= '0;
        row <= (row == height_last) ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + COL_BITS'(1);
      end
    end
  end

  // line store of even-row pair sums
  ib2s_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (pair_now),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (line_q)
  );

  // valid bits of the arithmetic pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= line_re;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload: pair, 2x2 sum, gain product
  always_ff @(posedge clk) begin
    s1_pair <= pair_now;
    s1_last <= is_last;
    s2_sum  <= SUM4_BITS'($signed(line_q)) + SUM4_BITS'(s1_pair);
    s2_last <= s1_last;
    s3_prod <= PROD_BITS'(s2_sum) * PROD_BITS'($signed({1'b0, scale_gain}));
    s3_last <= s2_last;
  end

  // divide by 1024 toward zero, then clip
  always_comb begin
    quot = (s3_prod + (s3_prod[PROD_BITS-1] ? ROUND_BIAS : PROD_BITS'(0))) >>> GAIN_SHIFT;
    if (quot > SAT_HI) begin
      result.binned_value = 16'(RESULT_MAX);
    end else if (quot < SAT_LO) begin
      result.binned_value = 16'(RESULT_MIN);
    end else begin
      result.binned_value = quot[15:0];
    end
    result.frame_end = s3_last;
  end

  // credit count for results not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      credit_used <= '0;
    end else if ((in_fire && produce) && !out_fire) begin
      credit_used <= credit_used + OUT_CNT_BITS'(1);
    end else if (!(in_fire && produce) && out_fire) begin
      credit_used <= credit_used - OUT_CNT_BITS'(1);
    end
  end

  // result queue feeding the output channel
  ib2s_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_data (result),
    .pop       (out_fire),
    .head      (q_head),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign binned_value = q_head.binned_value;
  assign frame_end    = q_head.frame_end;

  // credits equal items in the pipeline plus queued items
  `IB2S_ASSERT_NOW(a_credit_track, clk, rst, 1'b1, credit_used == q_count + OUT_CNT_BITS'(s1_valid) + OUT_CNT_BITS'(s2_valid) + OUT_CNT_BITS'(s3_valid))
  // a pixel at the row end wraps the column counter
  `IB2S_ASSERT_NEXT(a_col_wrap, clk, rst, in_fire && at_row_end && !cfg_fire, col == '0)
  // the row only moves at the row end
  `IB2S_ASSERT_NEXT(a_row_hold, clk, rst, in_fire && !at_row_end && !cfg_fire, $stable(row))
  // a result enters the pipeline only on an odd row
  `IB2S_ASSERT_NOW(a_read_odd_row, clk, rst, line_re, row[0] && !line_we)

endmodule

[rtl/ib2s_ram.sv]
// ----------------------------------------------------------------------------
// ib2s_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ib2s_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2048
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ib2s_out_fifo.sv]
// ----------------------------------------------------------------------------
// ib2s_out_fifo
// Small result queue between the arithmetic pipeline and the output channel.
// ----------------------------------------------------------------------------
`include "image_bin2x2_saturate_core_defines.svh"

module ib2s_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  ib2s_pkg::result_t                 push_data,
  input  logic                              pop,
  output ib2s_pkg::result_t                 head,
  output logic                              not_empty,
  output logic [ib2s_pkg::OUT_CNT_BITS-1:0] count
);

  import ib2s_pkg::*;

  result_t                 slots [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;

  // storage, no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - OUT_CNT_BITS'(1);
      end
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  // the credit scheme upstream must keep the queue from overflowing
  `IB2S_ASSERT_NOW(a_no_overflow, clk, rst, push && !pop, count < OUT_CNT_BITS'(OUT_DEPTH))
  // pointer distance matches the fill level
  `IB2S_ASSERT_NOW(a_ptr_level, clk, rst, count != OUT_CNT_BITS'(OUT_DEPTH), OUT_PTR_BITS'(wr_ptr - rd_ptr) == count[OUT_PTR_BITS-1:0])

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks image_bin2x2_saturate_core against a cycle-free predictor of the 2x2
// binning: pair sums, line store, Q8.8 gain with truncation toward zero,
// 16-bit clipping and end-of-frame marking. Short directed frames first, then
// random geometries and gains with random idling on both sides, one long
// output hold that backs up the core, and the start of a row at the widest
// setting.
// ----------------------------------------------------------------------------
module testbench;
  import ib2s_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int MAX_W         = 4096;
  localparam int PIX_BITS      = 24;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int WIDE_ITEMS    = 64;
  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRESSURE_PHASE = 4;
  localparam int MAX_REPORTS   = 30;
  localparam int CYCLE_LIMIT   = 400000;

  // index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [PIX_BITS-1:0] PIX_MAX = 24'h7FFFFF;
  localparam logic [PIX_BITS-1:0] PIX_MIN = 24'h800000;

  typedef enum int {PIX_FULL, PIX_SMALL, PIX_EDGE, PIX_MIXED} pix_mode_e;
  typedef enum int {
    GEOM_PLAIN, GEOM_NARROW_LOW, GEOM_WIDTH_HIGH_BITS, GEOM_SHORT_LOW, GEOM_TALL
  } geom_e;

  // predicted binning state and expected results
  class bin2x2_tracker;
    logic [12:0] line_width;
    logic [15:0] frame_height;
    logic [15:0] scale_gain;
    int unsigned col;
    int unsigned row;
    longint      first_of_pair;
    longint      line_sums [MAX_W/2];
    result_t     expected_bins [$];
    int          errors;
    int          pixels_seen;
    int          results_checked;

    function new();
      line_width   = LINE_WIDTH_RESET;
      frame_height = FRAME_HEIGHT_RESET;
      scale_gain   = SCALE_GAIN_RESET;
      errors = 0;
      pixels_seen = 0;
      results_checked = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col = 0;
      row = 0;
      first_of_pair = 0;
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction

    // register write; geometry writes restart the frame
    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_LINE_WIDTH: begin
          line_width = data[12:0];
          restart_frame();
        end
        CFG_FRAME_HEIGHT: begin
          frame_height = data;
          restart_frame();
        end
        CFG_SCALE_GAIN: begin
          scale_gain = data;
        end
        default: ;
      endcase
    endfunction

    // one accepted pixel item
    function void note_pixel(logic signed [PIX_BITS-1:0] px);
      int unsigned w;
      int unsigned h;
      longint      p;
      longint      pair;
      longint      sum4;
      longint      v;
      result_t     r;
      w = (line_width < 2) ? 2 : ((line_width > MAX_W) ? MAX_W : line_width);
      h = (frame_height < 2) ? 2 : frame_height;
      p = px;
      pixels_seen++;
      if (!col[0]) begin
        first_of_pair = p;
      end else begin
        pair = first_of_pair + p;
        if (!row[0]) begin
          line_sums[col >> 1] = pair;
        end else begin
          // average of four times Q8.8 gain, truncated toward zero, then clipped
          sum4 = line_sums[col >> 1] + pair;
          v = (sum4 * longint'(scale_gain)) / (longint'(1) << GAIN_SHIFT);
          if (v > RESULT_MAX) v = RESULT_MAX;
          else if (v < RESULT_MIN) v = RESULT_MIN;
          r.binned_value = v[15:0];
          r.frame_end = (row == (h & ~32'd1) - 1) && (col == (w & ~32'd1) - 1);
          expected_bins.push_back(r);
        end
      end
      // raster advance; dropped odd column or row still counts
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    // one accepted result item against the oldest prediction
    function void check_result(logic signed [15:0] value, logic last);
      result_t want;
      if (expected_bins.size() == 0) begin
        if (errors < MAX_REPORTS)
          $error("unexpected result: binned_value %0d frame_end %0b", value, last);
        errors++;
        return;
      end
      want = expected_bins.pop_front();
      results_checked++;
      if (value !== want.binned_value) begin
        if (errors < MAX_REPORTS)
          $error("binned_value: expected %0d, actual %0d", want.binned_value, value);
        errors++;
      end
      if (last !== want.frame_end) begin
        if (errors < MAX_REPORTS)
          $error("frame_end: expected %0b, actual %0b", want.frame_end, last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [PIX_BITS-1:0] pixel;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [15:0]         binned_value;
  logic                       frame_end;

  bin2x2_tracker sb;
  bit            calm = 1'b0;
  bit            hold_off = 1'b0;
  int            cycles = 0;

  image_bin2x2_saturate_core #(
    .MAX_WIDTH  (MAX_W),
    .PIXEL_BITS (PIX_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .binned_value (binned_value),
    .frame_end    (frame_end)
  );

  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // handshake monitor: register writes, pixel items in, result items out
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_pixel(pixel);
      if (out_valid && out_ready) sb.check_result(binned_value, frame_end);
    end
  end

  // result receiver: random stalls, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic logic [PIX_BITS-1:0] pick_pixel(pix_mode_e mode);
    case (mode)
      PIX_FULL:  return PIX_BITS'($urandom());
      PIX_SMALL: return PIX_BITS'(int'($urandom_range(0, 600)) - 300);
      PIX_EDGE:  return $urandom_range(0, 1) ? PIX_MAX - PIX_BITS'($urandom_range(0, 3))
                                             : PIX_MIN + PIX_BITS'($urandom_range(0, 3));
      default:   return pick_pixel(pix_mode_e'($urandom_range(PIX_FULL, PIX_EDGE)));
    endcase
  endfunction

  // offer one pixel item, idling at random first
  task automatic send_pixel(input logic [PIX_BITS-1:0] value);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write; valid stays up for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop offering, wait for every due result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase_no;
    int          rand_items;
    int          n;
    int unsigned ew;
    int unsigned eh;
    geom_e       geom;
    pix_mode_e   mode;
    logic [15:0] w_data;
    logic [15:0] h_data;
    logic [15:0] g_data;

    sb = new();
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pixel <= '0;
    out_ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: a few pixels into a full-width row, nothing comes out
    send_pixel(24'h000123);
    send_pixel(24'hFFFEDC);
    settle();

    // 2x2 frames at unity gain: clipping both ways, truncation of a negative sum
    write_reg(CFG_LINE_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    write_reg(CFG_SCALE_GAIN, 16'd256);
    cfg_valid <= 1'b0;
    repeat (4) send_pixel(PIX_MAX);
    repeat (4) send_pixel(PIX_MIN);
    send_pixel(24'hFFFFFF);
    repeat (3) send_pixel(24'h000000);
    settle();

    // top gain on a small negative sum
    write_reg(CFG_SCALE_GAIN, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    settle();

    // odd width and height drop the last column and row; unused index ignored
    write_reg(CFG_UNUSED, 16'hA5A5);
    write_reg(CFG_LINE_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    write_reg(CFG_SCALE_GAIN, 16'd300);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_pixel(PIX_BITS'(i * 1000 - 3000));
    settle();

    // random settings phases, mostly complete frames
    phase_no = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase_no++;
      ew = $urandom_range(2, 12);
      eh = $urandom_range(2, 7);
      geom = $urandom_range(0, 1) ? GEOM_PLAIN
                                  : geom_e'($urandom_range(GEOM_NARROW_LOW, GEOM_TALL));
      if (phase_no == PRESSURE_PHASE) begin
        geom = GEOM_PLAIN;
        ew = 8;
        eh = 8;
      end
      w_data = 16'(ew);
      h_data = 16'(eh);
      case (geom)
        GEOM_NARROW_LOW: begin
          ew = 2;
          w_data = 16'($urandom_range(0, 1));
        end
        GEOM_WIDTH_HIGH_BITS: w_data = w_data | 16'hE000;
        GEOM_SHORT_LOW: begin
          eh = 2;
          h_data = 16'($urandom_range(0, 1));
        end
        GEOM_TALL: h_data = 16'hFFFF;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0:       g_data = 16'($urandom());
        1:       g_data = 16'd256;
        2:       g_data = 16'($urandom_range(0, 600));
        3:       g_data = 16'($urandom());
        4:       g_data = 16'hFFFF;
        default: g_data = 16'd0;
      endcase
      calm = (phase_no >= 8 && phase_no < 11);

      write_reg(CFG_LINE_WIDTH, w_data);
      write_reg(CFG_FRAME_HEIGHT, h_data);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_SCALE_GAIN, g_data);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom()));
      cfg_valid <= 1'b0;

      mode = pix_mode_e'($urandom_range(PIX_FULL, PIX_MIXED));
      if (phase_no == PRESSURE_PHASE) n = 3 * ew * eh;
      else if (geom == GEOM_TALL) n = $urandom_range(20, 80);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2 * ew * eh);
      else n = ew * eh * $urandom_range(1, 3);

      // receiver holds off while items keep coming
      if (phase_no == PRESSURE_PHASE) hold_off = 1'b1;
      repeat (n) send_pixel(pick_pixel(mode));
      rand_items += n;
      settle();
    end
    calm = 1'b0;

    // start of a row at the widest setting, width given above range
    write_reg(CFG_LINE_WIDTH, 16'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    write_reg(CFG_SCALE_GAIN, 16'($urandom()));
    cfg_valid <= 1'b0;
    repeat (WIDE_ITEMS) send_pixel(pick_pixel(PIX_FULL));
    settle();

    $display("covered %0d pixel items in %0d random phases plus directed frames,",
             sb.pixels_seen, phase_no);
    $display("odd and clamped sizes, a %0d-wide row start, a %0d-cycle output hold: %0d results",
             MAX_W, HOLD_CYCLES, sb.results_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[image_bin2x2_saturate_core.f]
+incdir+rtl
rtl/ib2s_pkg.sv
rtl/ib2s_ram.sv
rtl/ib2s_out_fifo.sv
rtl/image_bin2x2_saturate_core.sv
dv/testbench.sv
